>>> sv/sczc_pkg.sv
// ----------------------------------------------------------------------------
// sczc_pkg: shared definitions of the segment versus circle zone checker
// Command and status codes, default sizes and the pipeline status record.
// ----------------------------------------------------------------------------
`default_nettype none

package sczc_pkg;

    localparam int MAX_ZONES_DEF  = 64;
    localparam int COORD_BITS_DEF = 14;

    localparam int FUNC_BITS   = 2;
    localparam int STATUS_BITS = 3;
    localparam int INDEX_BITS  = 6;

    localparam logic [FUNC_BITS-1:0] FN_CLEAR  = 2'd0;
    localparam logic [FUNC_BITS-1:0] FN_APPEND = 2'd1;
    localparam logic [FUNC_BITS-1:0] FN_WAYPT  = 2'd2;
    localparam logic [FUNC_BITS-1:0] FN_NOP    = 2'd3;

    localparam logic [STATUS_BITS-1:0] STS_ACCEPTED = 3'd0;
    localparam logic [STATUS_BITS-1:0] STS_CLEAR    = 3'd1;
    localparam logic [STATUS_BITS-1:0] STS_HIT      = 3'd2;
    localparam logic [STATUS_BITS-1:0] STS_REPEAT   = 3'd3;
    localparam logic [STATUS_BITS-1:0] STS_FULL     = 3'd4;

    typedef struct packed {
        logic busy;
        logic valid;
        logic hit;
    } t_pipe_stat;

endpackage

`default_nettype wire

>>> sv/sczc_if.sv
// ----------------------------------------------------------------------------
// sczc_in_if / sczc_out_if: request and response channels
// Valid/ready channels carrying one request or one response.
// ----------------------------------------------------------------------------
`default_nettype none

interface sczc_in_if #(
    parameter int COORD_BITS = sczc_pkg::COORD_BITS_DEF
);
    logic                           valid;
    logic                           ready;
    logic [sczc_pkg::FUNC_BITS-1:0] func;
    logic [COORD_BITS-1:0]          pos_x;
    logic [COORD_BITS-1:0]          pos_y;
    logic [COORD_BITS-1:0]          radius;

    modport source (output valid, output func, output pos_x, output pos_y,
                    output radius, input ready);
    modport sink   (input valid, input func, input pos_x, input pos_y,
                    input radius, output ready);
endinterface

interface sczc_out_if #(
    parameter int COORD_BITS = sczc_pkg::COORD_BITS_DEF
);
    logic                             valid;
    logic                             ready;
    logic [sczc_pkg::STATUS_BITS-1:0] status;
    logic [sczc_pkg::INDEX_BITS-1:0]  zone_index;
    logic [COORD_BITS-1:0]            zone_x;
    logic [COORD_BITS-1:0]            zone_y;

    modport source (output valid, output status, output zone_index,
                    output zone_x, output zone_y, input ready);
    modport sink   (input valid, input status, input zone_index,
                    input zone_x, input zone_y, output ready);
endinterface

`default_nettype wire

>>> sv/sczc_ram.sv
// ----------------------------------------------------------------------------
// sczc_ram: generic single-write, single-read synchronous RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module sczc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                            i_wdata,
    input  wire logic                                        i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

>>> sv/sczc_hit_pipe.sv
// ----------------------------------------------------------------------------
// sczc_hit_pipe: segment versus circle test, one zone per cycle
// Four register stages: differences, products, sums, classification with
// final products; the last compare is resolved at the output.
// ----------------------------------------------------------------------------
`default_nettype none

module sczc_hit_pipe #(
    parameter int COORD_BITS = sczc_pkg::COORD_BITS_DEF,
    parameter int IDX_BITS   = 7
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_flush,
    input  wire logic                    i_valid,
    input  wire logic [IDX_BITS-1:0]     i_idx,
    input  wire logic [3*COORD_BITS-1:0] i_zone,
    input  wire logic [COORD_BITS-1:0]   i_ax,
    input  wire logic [COORD_BITS-1:0]   i_ay,
    input  wire logic [COORD_BITS-1:0]   i_bx,
    input  wire logic [COORD_BITS-1:0]   i_by,
    output sczc_pkg::t_pipe_stat         o_stat,
    output logic      [IDX_BITS-1:0]     o_idx,
    output logic      [COORD_BITS-1:0]   o_zx,
    output logic      [COORD_BITS-1:0]   o_zy
);

    localparam int W   = COORD_BITS;
    localparam int PW  = 2 * W + 2;
    localparam int MW  = 2 * W + 1;
    localparam int PRW = 2 * MW;

    logic [W-1:0] w_cx, w_cy, w_cr;
    assign w_cx = i_zone[W-1:0];
    assign w_cy = i_zone[2*W-1:W];
    assign w_cr = i_zone[3*W-1:2*W];

    function automatic logic signed [PW-1:0] ext(input logic [W-1:0] v);
        ext = $signed({{(PW-W){1'b0}}, v});
    endfunction

    // stage 1: differences
    logic                 r1_v;
    logic [IDX_BITS-1:0]  r1_idx;
    logic [W-1:0]         r1_zx, r1_zy;
    logic signed [PW-1:0] r1_bx, r1_by, r1_ax, r1_ay, r1_dx, r1_dy, r1_r;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_flush) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= i_valid;
        end
        r1_idx <= i_idx;
        r1_zx  <= w_cx;
        r1_zy  <= w_cy;
        r1_bx  <= ext(i_bx) - ext(w_cx);
        r1_by  <= ext(i_by) - ext(w_cy);
        r1_ax  <= ext(i_ax) - ext(w_cx);
        r1_ay  <= ext(i_ay) - ext(w_cy);
        r1_dx  <= ext(i_ax) - ext(i_bx);
        r1_dy  <= ext(i_ay) - ext(i_by);
        r1_r   <= ext(w_cr);
    end

    // stage 2: products
    logic                 r2_v;
    logic [IDX_BITS-1:0]  r2_idx;
    logic [W-1:0]         r2_zx, r2_zy;
    logic signed [PW-1:0] r2_bxx, r2_byy, r2_axx, r2_ayy, r2_rr;
    logic signed [PW-1:0] r2_bdx, r2_bdy, r2_dxx, r2_dyy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_flush) begin
            r2_v <= 1'b0;
        end else begin
            r2_v <= r1_v;
        end
        r2_idx <= r1_idx;
        r2_zx  <= r1_zx;
        r2_zy  <= r1_zy;
        r2_bxx <= r1_bx * r1_bx;
        r2_byy <= r1_by * r1_by;
        r2_axx <= r1_ax * r1_ax;
        r2_ayy <= r1_ay * r1_ay;
        r2_rr  <= r1_r * r1_r;
        r2_bdx <= r1_bx * r1_dx;
        r2_bdy <= r1_by * r1_dy;
        r2_dxx <= r1_dx * r1_dx;
        r2_dyy <= r1_dy * r1_dy;
    end

    // stage 3: f(0), f(1), half linear term, quadratic term
    logic                 r3_v;
    logic [IDX_BITS-1:0]  r3_idx;
    logic [W-1:0]         r3_zx, r3_zy;
    logic signed [PW-1:0] r3_f0, r3_f1, r3_h, r3_qa;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_flush) begin
            r3_v <= 1'b0;
        end else begin
            r3_v <= r2_v;
        end
        r3_idx <= r2_idx;
        r3_zx  <= r2_zx;
        r3_zy  <= r2_zy;
        r3_f0  <= r2_bxx + r2_byy - r2_rr;
        r3_f1  <= r2_axx + r2_ayy - r2_rr;
        r3_h   <= r2_bdx + r2_bdy;
        r3_qa  <= r2_dxx + r2_dyy;
    end

    // stage 4: classify, square the half linear term, form qa*f0
    logic                 n4_hit, n4_cmp;
    logic signed [PW-1:0] w_nh;
    logic [PRW-1:0]       w_mh, w_qa, w_f0;

    assign w_nh = -r3_h;
    assign w_mh = {{(PRW-MW){1'b0}}, w_nh[MW-1:0]};
    assign w_qa = {{(PRW-MW){1'b0}}, r3_qa[MW-1:0]};
    assign w_f0 = {{(PRW-MW){1'b0}}, r3_f0[MW-1:0]};

    always_comb begin
        n4_hit = 1'b0;
        n4_cmp = 1'b0;
        if (r3_f0 < 0 || r3_f1 < 0) begin
            n4_hit = 1'b1;
        end else if (r3_f0 == 0 && r3_f1 == 0) begin
            n4_hit = 1'b0;
        end else if (r3_f0 == 0) begin
            n4_hit = (r3_h < 0);
        end else if (r3_f1 == 0) begin
            n4_hit = (r3_f0 < r3_qa);
        end else if (r3_h >= 0 || w_nh >= r3_qa) begin
            n4_hit = 1'b0;
        end else begin
            n4_cmp = 1'b1;
        end
    end

    logic                r4_v, r4_hit, r4_cmp;
    logic [IDX_BITS-1:0] r4_idx;
    logic [W-1:0]        r4_zx, r4_zy;
    logic [PRW-1:0]      r4_p1, r4_p2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_flush) begin
            r4_v <= 1'b0;
        end else begin
            r4_v <= r3_v;
        end
        r4_idx <= r3_idx;
        r4_zx  <= r3_zx;
        r4_zy  <= r3_zy;
        r4_hit <= n4_hit;
        r4_cmp <= n4_cmp;
        r4_p1  <= w_mh * w_mh;
        r4_p2  <= w_qa * w_f0;
    end

    assign o_stat.busy  = r1_v | r2_v | r3_v | r4_v;
    assign o_stat.valid = r4_v;
    assign o_stat.hit   = r4_hit | (r4_cmp && (r4_p1 >= r4_p2));
    assign o_idx        = r4_idx;
    assign o_zx         = r4_zx;
    assign o_zy         = r4_zy;

endmodule

`default_nettype wire

>>> sv/segment_circle_zone_check.sv
// ----------------------------------------------------------------------------
// segment_circle_zone_check: flight segment versus circular no-fly zones
// Requests on i_req clear the plan, append a zone, present a waypoint or do
// nothing; each request yields exactly one response on o_rsp, in order.
//
// Zones live in a synchronous RAM. A waypoint after the first that differs
// from the previous one starts a scan that reads one zone per cycle into a
// four-stage test pipeline; the scan stops at the first zone hit. Clear,
// append, first and repeated waypoints go from idle straight to the done
// state; a tested waypoint passes through the scan state until a zone is hit
// or every stored zone has cleared the pipeline. One request is in work at a
// time; the next is accepted once the response is loaded into the output
// register, also while that response still waits. A stalled receiver holds
// o_rsp and, once the next result is ready, stalls i_req. Reset (synchronous,
// active low) empties the zone table, forgets the previous waypoint and
// drops any response held; RAM contents are left.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_circle_zone_check #(
    parameter int MAX_ZONES  = sczc_pkg::MAX_ZONES_DEF,
    parameter int COORD_BITS = sczc_pkg::COORD_BITS_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    sczc_in_if.sink     i_req,
    sczc_out_if.source  o_rsp
);

    localparam int W  = COORD_BITS;
    localparam int CW = $clog2(MAX_ZONES + 1);
    localparam int AW = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]                       r_state, n_state;
    logic [CW-1:0]                    r_count, n_count;
    logic                             r_have_prev, n_have_prev;
    logic [W-1:0]                     r_ax, n_ax, r_ay, n_ay;
    logic [W-1:0]                     r_bx, n_bx, r_by, n_by;
    logic [CW-1:0]                    r_idx, n_idx;
    logic                             r_rd_v, n_rd_v;
    logic [CW-1:0]                    r_rd_idx, n_rd_idx;
    logic [sczc_pkg::STATUS_BITS-1:0] r_res_sts, n_res_sts;
    logic [CW-1:0]                    r_res_idx, n_res_idx;
    logic [W-1:0]                     r_res_zx, n_res_zx, r_res_zy, n_res_zy;
    logic                             r_out_v, n_out_v;
    logic [sczc_pkg::STATUS_BITS-1:0] r_out_sts, n_out_sts;
    logic [CW-1:0]                    r_out_idx, n_out_idx;
    logic [W-1:0]                     r_out_zx, n_out_zx, r_out_zy, n_out_zy;

    logic                 w_accept, w_take, w_issue, w_full, w_we, w_hit;
    logic [3*W-1:0]       w_rdata;
    sczc_pkg::t_pipe_stat w_stat;
    logic [CW-1:0]        w_pidx;
    logic [W-1:0]         w_pzx, w_pzy;

    assign i_req.ready = (r_state == ST_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_take      = r_out_v && o_rsp.ready;
    assign w_full      = (r_count >= CW'(MAX_ZONES));
    assign w_we        = w_accept && (i_req.func == sczc_pkg::FN_APPEND) && !w_full;
    assign w_hit       = w_stat.valid && w_stat.hit;
    assign w_issue     = (r_state == ST_SCAN) && (r_idx < r_count) && !w_hit;

    sczc_ram #(
        .WIDTH (3 * W),
        .DEPTH (MAX_ZONES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata ({i_req.radius, i_req.pos_y, i_req.pos_x}),
        .i_re    (w_issue),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (w_rdata)
    );

    sczc_hit_pipe #(
        .COORD_BITS (W),
        .IDX_BITS   (CW)
    ) u_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flush (w_hit),
        .i_valid (r_rd_v),
        .i_idx   (r_rd_idx),
        .i_zone  (w_rdata),
        .i_ax    (r_ax),
        .i_ay    (r_ay),
        .i_bx    (r_bx),
        .i_by    (r_by),
        .o_stat  (w_stat),
        .o_idx   (w_pidx),
        .o_zx    (w_pzx),
        .o_zy    (w_pzy)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_have_prev = r_have_prev;
        n_ax        = r_ax;
        n_ay        = r_ay;
        n_bx        = r_bx;
        n_by        = r_by;
        n_idx       = r_idx;
        n_rd_v      = 1'b0;
        n_rd_idx    = r_idx;
        n_res_sts   = r_res_sts;
        n_res_idx   = r_res_idx;
        n_res_zx    = r_res_zx;
        n_res_zy    = r_res_zy;
        n_out_v     = r_out_v && !w_take;
        n_out_sts   = r_out_sts;
        n_out_idx   = r_out_idx;
        n_out_zx    = r_out_zx;
        n_out_zy    = r_out_zy;

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_res_sts = sczc_pkg::STS_ACCEPTED;
                    n_res_idx = '0;
                    n_res_zx  = '0;
                    n_res_zy  = '0;
                    n_state   = ST_DONE;
                    case (i_req.func)
                        sczc_pkg::FN_CLEAR: begin
                            n_count     = '0;
                            n_have_prev = 1'b0;
                        end
                        sczc_pkg::FN_APPEND: begin
                            if (w_full) begin
                                n_res_sts = sczc_pkg::STS_FULL;
                            end else begin
                                n_count = r_count + CW'(1);
                            end
                        end
                        sczc_pkg::FN_WAYPT: begin
                            if (!r_have_prev) begin
                                n_have_prev = 1'b1;
                                n_ax        = i_req.pos_x;
                                n_ay        = i_req.pos_y;
                            end else if (r_ax == i_req.pos_x && r_ay == i_req.pos_y) begin
                                n_res_sts = sczc_pkg::STS_REPEAT;
                            end else begin
                                n_bx    = i_req.pos_x;
                                n_by    = i_req.pos_y;
                                n_idx   = '0;
                                n_state = ST_SCAN;
                            end
                        end
                        default: begin
                            n_res_sts = sczc_pkg::STS_ACCEPTED;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                n_rd_v = w_issue;
                if (w_issue) begin
                    n_idx = r_idx + CW'(1);
                end
                if (w_hit) begin
                    n_rd_v    = 1'b0;
                    n_res_sts = sczc_pkg::STS_HIT;
                    n_res_idx = w_pidx;
                    n_res_zx  = w_pzx;
                    n_res_zy  = w_pzy;
                    n_ax      = r_bx;
                    n_ay      = r_by;
                    n_state   = ST_DONE;
                end else if (!w_issue && !r_rd_v && !w_stat.busy) begin
                    n_res_sts = sczc_pkg::STS_CLEAR;
                    n_res_idx = '0;
                    n_res_zx  = '0;
                    n_res_zy  = '0;
                    n_ax      = r_bx;
                    n_ay      = r_by;
                    n_state   = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_v || w_take) begin
                    n_out_v   = 1'b1;
                    n_out_sts = r_res_sts;
                    n_out_idx = r_res_idx;
                    n_out_zx  = r_res_zx;
                    n_out_zy  = r_res_zy;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_have_prev <= 1'b0;
            r_ax        <= '0;
            r_ay        <= '0;
            r_rd_v      <= 1'b0;
            r_out_v     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_have_prev <= n_have_prev;
            r_ax        <= n_ax;
            r_ay        <= n_ay;
            r_rd_v      <= n_rd_v;
            r_out_v     <= n_out_v;
        end
        r_bx      <= n_bx;
        r_by      <= n_by;
        r_idx     <= n_idx;
        r_rd_idx  <= n_rd_idx;
        r_res_sts <= n_res_sts;
        r_res_idx <= n_res_idx;
        r_res_zx  <= n_res_zx;
        r_res_zy  <= n_res_zy;
        r_out_sts <= n_out_sts;
        r_out_idx <= n_out_idx;
        r_out_zx  <= n_out_zx;
        r_out_zy  <= n_out_zy;
    end

    assign o_rsp.valid      = r_out_v;
    assign o_rsp.status     = r_out_sts;
    assign o_rsp.zone_index = sczc_pkg::INDEX_BITS'(r_out_idx);
    assign o_rsp.zone_x     = r_out_zx;
    assign o_rsp.zone_y     = r_out_zy;

endmodule

`default_nettype wire

>>> sv/sczc_checker.sv
// ----------------------------------------------------------------------------
// sczc_checker: port-level checks of the zone checker
// Watches the request and response channels and flags illegal behavior.
// ----------------------------------------------------------------------------
`default_nettype none

module sczc_checker #(
    parameter int COORD_BITS = sczc_pkg::COORD_BITS_DEF
) (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             i_in_valid,
    input wire logic                             i_in_ready,
    input wire logic                             i_out_valid,
    input wire logic                             i_out_ready,
    input wire logic [sczc_pkg::STATUS_BITS-1:0] i_status,
    input wire logic [sczc_pkg::INDEX_BITS-1:0]  i_zone_index,
    input wire logic [COORD_BITS-1:0]            i_zone_x,
    input wire logic [COORD_BITS-1:0]            i_zone_y
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("response dropped while stalled");

    a_zone_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status != sczc_pkg::STS_HIT |->
            i_zone_index == '0 && i_zone_x == '0 && i_zone_y == '0)
        else $error("zone fields set without a hit");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_status <= sczc_pkg::STS_FULL)
        else $error("status code out of range");

    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second request taken while one is in work");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("response present after reset");

endmodule

bind segment_circle_zone_check sczc_checker #(
    .COORD_BITS (COORD_BITS)
) u_sczc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_req.valid),
    .i_in_ready   (i_req.ready),
    .i_out_valid  (o_rsp.valid),
    .i_out_ready  (o_rsp.ready),
    .i_status     (o_rsp.status),
    .i_zone_index (o_rsp.zone_index),
    .i_zone_x     (o_rsp.zone_x),
    .i_zone_y     (o_rsp.zone_y)
);

`default_nettype wire
